>>> rtl/core/sqd_pkg.sv
// Shared types and constants for the shortest queue dispatcher.
// No dependencies; imported by shortest_queue_dispatcher_core.
package sqd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RET_CHK,
        ST_RET_CMP,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    typedef logic [1:0] t_status;

    localparam t_status STAT_OK   = 2'd0;
    localparam t_status STAT_FULL = 2'd1;
    localparam t_status STAT_OVF  = 2'd2;

    localparam int TIME_W    = 32;
    localparam int SERVICE_W = 16;
    localparam int SRVNUM_W  = 5;

endpackage

>>> rtl/core/shortest_queue_dispatcher_core.sv
// Join-shortest-queue dispatcher over a bank of first-in first-out servers.
// Depends on sqd_pkg for the sequencer state type and status codes.
//
// Each input transaction carries an arrival time and a service time. The block
// raises the effective arrival time to the previous one if needed, retires every
// queued job that has finished by then, picks the active server with the fewest
// jobs (lowest index on ties) and returns the server number from 1, the finish
// time and a status (accepted, queue full, or finish time overflow). A dropped
// job reports server 0 and finish time 0. A small sequencer walks all servers
// to retire finished heads, each retirement costing one read of the finish-time
// memory and one compare; a server whose head is still in service also spends
// a read and the compare that stops its retirement. It then walks the active
// servers once more with a single length comparator, and finally does the
// start-time add and queue write, which waits while the previous result is
// still held by an output stall. The block takes no new input until the job's
// result is registered; the result sits in an output register so the next job
// can start while it waits to be taken. The server count register may be
// written at any time the block is idle; zero acts as one and values above
// MAX_SERVERS act as MAX_SERVERS.
module shortest_queue_dispatcher_core #(
    parameter int MAX_SERVERS = 16,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [sqd_pkg::TIME_W-1:0]     i_arrival_time,
    input  logic [sqd_pkg::SERVICE_W-1:0]  i_service_time,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sqd_pkg::SRVNUM_W-1:0]   o_server_number,
    output logic [sqd_pkg::TIME_W-1:0]     o_finish_time,
    output logic [1:0]                     o_status,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sqd_pkg::SRVNUM_W-1:0]   i_cfg_server_count
);
    import sqd_pkg::*;

    localparam int SW    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW    = $clog2(MAX_SERVERS + 1);
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int LW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DEPTH = MAX_SERVERS * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CFGW  = (CW > SRVNUM_W) ? CW : SRVNUM_W;

    localparam logic [SW-1:0] LAST_SRV = SW'(MAX_SERVERS - 1);
    localparam logic [QW-1:0] LAST_SLOT = QW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] FULL_LEN = LW'(QUEUE_DEPTH);
    localparam logic [AW:0]   BASE_STEP = (AW + 1)'(QUEUE_DEPTH);

    t_state r_state, n_state;

    // Per-server queue bookkeeping, cleared by reset.
    logic [LW-1:0]     r_len   [MAX_SERVERS];
    logic [QW-1:0]     r_head  [MAX_SERVERS];
    logic [QW-1:0]     r_tail  [MAX_SERVERS];
    logic [TIME_W-1:0] r_lastf [MAX_SERVERS];

    // Finish times of queued jobs, one region of QUEUE_DEPTH entries per server.
    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rd_data;

    logic [TIME_W-1:0]    r_last_arr;
    logic [SRVNUM_W-1:0]  r_cfg;
    logic [TIME_W-1:0]    r_now;
    logic [SERVICE_W-1:0] r_svc;
    logic [CW-1:0]        r_active;
    logic [SW-1:0]        r_srv;
    logic [AW-1:0]        r_base;
    logic [SW-1:0]        r_best;
    logic [AW-1:0]        r_best_base;
    logic [LW-1:0]        r_best_len;

    logic                 r_out_valid;
    logic [SRVNUM_W-1:0]  r_out_srv;
    logic [TIME_W-1:0]    r_out_fin;
    t_status              r_out_stat;

    logic                 in_take;
    logic                 out_free;
    logic                 head_done;
    logic                 srv_last_active;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [TIME_W-1:0]    start_t;
    logic [TIME_W:0]      fin_sum;
    logic [CFGW-1:0]      cfg_wide;
    logic [CW-1:0]        active_cnt;
    logic [AW:0]          base_next;

    // Output logic of the sequencer.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;
        out_free    = !r_out_valid || !i_out_stall;
    end

    assign in_take         = i_in_valid && !o_in_stall;
    assign head_done       = (r_rd_data <= r_now);
    assign srv_last_active = ({{(CW > SW ? CW - SW : 0){1'b0}}, r_srv} == CW'(r_active - 1'b1));
    assign rd_addr         = r_base + AW'(r_head[r_srv]);
    assign wr_addr         = r_best_base + AW'(r_tail[r_best]);
    assign start_t         = ((r_best_len != '0) && (r_lastf[r_best] > r_now))
                             ? r_lastf[r_best] : r_now;
    assign fin_sum         = {1'b0, start_t} + (TIME_W + 1)'(r_svc);
    assign base_next       = {1'b0, r_base} + BASE_STEP;

    // Saturate the configured count into 1..MAX_SERVERS.
    always_comb begin
        cfg_wide = CFGW'(r_cfg);
        if (cfg_wide == '0) begin
            active_cnt = CW'(1);
        end else if (cfg_wide > CFGW'(MAX_SERVERS)) begin
            active_cnt = CW'(MAX_SERVERS);
        end else begin
            active_cnt = CW'(cfg_wide);
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) n_state = ST_RET_CHK;
            end
            ST_RET_CHK: begin
                if (r_len[r_srv] != '0) begin
                    n_state = ST_RET_CMP;
                end else if (r_srv == LAST_SRV) begin
                    n_state = ST_SCAN;
                end
            end
            ST_RET_CMP: begin
                if (head_done || r_srv != LAST_SRV) begin
                    n_state = ST_RET_CHK;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (srv_last_active) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_last_arr <= '0;
            r_cfg      <= SRVNUM_W'(16);
            for (int i = 0; i < MAX_SERVERS; i++) begin
                r_len[i]   <= '0;
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_lastf[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_cfg <= i_cfg_server_count;
            if (in_take) begin
                r_last_arr <= (i_arrival_time > r_last_arr) ? i_arrival_time : r_last_arr;
            end
            if (r_state == ST_RET_CMP && head_done) begin
                r_head[r_srv] <= (r_head[r_srv] == LAST_SLOT) ? '0 : r_head[r_srv] + 1'b1;
                r_len[r_srv]  <= r_len[r_srv] - 1'b1;
            end
            if (r_state == ST_DECIDE && out_free && r_best_len < FULL_LEN && !fin_sum[TIME_W]) begin
                r_tail[r_best]  <= (r_tail[r_best] == LAST_SLOT) ? '0 : r_tail[r_best] + 1'b1;
                r_len[r_best]   <= r_best_len + 1'b1;
                r_lastf[r_best] <= fin_sum[TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DECIDE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer datapath: counters, scan result and the result register.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now    <= (i_arrival_time > r_last_arr) ? i_arrival_time : r_last_arr;
            r_svc    <= (i_service_time == '0) ? SERVICE_W'(1) : i_service_time;
            r_active <= active_cnt;
            r_srv    <= '0;
            r_base   <= '0;
        end
        if ((r_state == ST_RET_CHK && r_len[r_srv] == '0)
            || (r_state == ST_RET_CMP && !head_done)) begin
            if (r_srv == LAST_SRV) begin
                r_srv  <= '0;
                r_base <= '0;
            end else begin
                r_srv  <= r_srv + 1'b1;
                r_base <= base_next[AW-1:0];
            end
        end
        if (r_state == ST_SCAN) begin
            if (r_srv == '0 || r_len[r_srv] < r_best_len) begin
                r_best      <= r_srv;
                r_best_base <= r_base;
                r_best_len  <= r_len[r_srv];
            end
            r_srv  <= r_srv + 1'b1;
            r_base <= base_next[AW-1:0];
        end
        if (r_state == ST_DECIDE && out_free) begin
            if (r_best_len >= FULL_LEN) begin
                r_out_srv  <= '0;
                r_out_fin  <= '0;
                r_out_stat <= STAT_FULL;
            end else if (fin_sum[TIME_W]) begin
                r_out_srv  <= '0;
                r_out_fin  <= '0;
                r_out_stat <= STAT_OVF;
            end else begin
                r_out_srv  <= SRVNUM_W'(r_best) + 1'b1;
                r_out_fin  <= fin_sum[TIME_W-1:0];
                r_out_stat <= STAT_OK;
            end
        end
    end

    // Finish-time memory: one read port for retirement, one write port for joins.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE && out_free && r_best_len < FULL_LEN && !fin_sum[TIME_W]) begin
            r_mem[wr_addr] <= fin_sum[TIME_W-1:0];
        end
        if (r_state == ST_RET_CHK) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_server_number = r_out_srv;
    assign o_finish_time   = r_out_fin;
    assign o_status        = r_out_stat;

    // A head compare always follows the memory read that feeds it.
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RET_CMP) |-> ($past(r_state) == ST_RET_CHK))
        else $error("head compare without a preceding memory read");

    // A dropped job never names a server.
    a_drop_no_server: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_OK) |-> (o_server_number == '0))
        else $error("dropped job reports a server");

    // An accepted job never reports a server beyond the active count.
    a_server_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_OK)
            |-> (o_server_number != '0 && CW'(o_server_number) <= r_active))
        else $error("reported server outside the active range");

endmodule

>>> test/tb_shortest_queue_dispatcher_core.sv
// Self-checking testbench for shortest_queue_dispatcher_core.
// Depends on sqd_pkg and the core; predicts each dispatch decision in place and
// checks every returned transaction against it.
`timescale 1ns / 1ps

module tb_shortest_queue_dispatcher_core;
    import sqd_pkg::*;

    localparam int MAX_SERVERS = 16;
    localparam int QUEUE_DEPTH = 64;
    // One job walks every server, may pop up to a full bank of queues, then
    // scans the active servers; this bounds the drain time after the last job.
    localparam int JOB_CYCLES   = MAX_SERVERS * (2 * QUEUE_DEPTH + 2) + 4;
    localparam int STALL_LIMIT  = 40 * JOB_CYCLES;

    typedef struct packed {
        logic [TIME_W-1:0]    arrival;
        logic [SERVICE_W-1:0] service;
    } t_job;

    typedef struct packed {
        logic [SRVNUM_W-1:0] server;
        logic [TIME_W-1:0]   finish;
        t_status             status;
    } t_dispatch;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [TIME_W-1:0]    i_arrival_time;
    logic [SERVICE_W-1:0] i_service_time;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [SRVNUM_W-1:0]  o_server_number;
    logic [TIME_W-1:0]    o_finish_time;
    logic [1:0]           o_status;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [SRVNUM_W-1:0]  i_cfg_server_count;

    // Handshake state as seen at the rising edge, for the input driver.
    logic                 o_in_stall_q;

    shortest_queue_dispatcher_core #(
        .MAX_SERVERS(MAX_SERVERS),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_arrival_time(i_arrival_time),
        .i_service_time(i_service_time),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_server_number(o_server_number),
        .o_finish_time(o_finish_time),
        .o_status(o_status),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_server_count(i_cfg_server_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: a private copy of every server queue.
    logic [TIME_W-1:0] mdl_fin_store [MAX_SERVERS][QUEUE_DEPTH];
    int unsigned       mdl_len  [MAX_SERVERS];
    int unsigned       mdl_head [MAX_SERVERS];
    int unsigned       mdl_tail [MAX_SERVERS];
    logic [TIME_W-1:0] mdl_last_fin [MAX_SERVERS];
    logic [TIME_W-1:0] mdl_now;
    logic [4:0]        mdl_server_count;

    t_job      pending_jobs[$];
    t_dispatch expected_dispatches[$];

    int  error_count;
    int  idle_cycles;
    bit  calm;          // no random idling in the closing stretch
    int  send_gap;
    int  recv_gap;

    function automatic t_dispatch predict_dispatch(t_job job);
        t_dispatch   d;
        int unsigned active;
        int unsigned best;
        int unsigned h;
        logic [TIME_W-1:0] start;
        logic [TIME_W:0]   fin;
        logic [SERVICE_W-1:0] svc;
        svc = (job.service == '0) ? SERVICE_W'(1) : job.service;
        active = mdl_server_count;
        if (active == 0) active = 1;
        if (active > MAX_SERVERS) active = MAX_SERVERS;
        if (job.arrival > mdl_now) mdl_now = job.arrival;
        // Departures happen before the arrival, on every server, active or not.
        for (int s = 0; s < MAX_SERVERS; s++) begin
            while (mdl_len[s] > 0) begin
                h = mdl_head[s];
                if (mdl_fin_store[s][h] > mdl_now) break;
                mdl_head[s] = (h + 1) % QUEUE_DEPTH;
                mdl_len[s]--;
            end
        end
        best = 0;
        for (int s = 1; s < active; s++)
            if (mdl_len[s] < mdl_len[best]) best = s;
        d.server = '0;
        d.finish = '0;
        if (mdl_len[best] >= QUEUE_DEPTH) begin
            d.status = STAT_FULL;
            return d;
        end
        start = (mdl_len[best] > 0 && mdl_last_fin[best] > mdl_now) ?
                mdl_last_fin[best] : mdl_now;
        fin = {1'b0, start} + (TIME_W + 1)'(svc);
        if (fin[TIME_W]) begin
            d.status = STAT_OVF;
            return d;
        end
        mdl_fin_store[best][mdl_tail[best]] = fin[TIME_W-1:0];
        mdl_tail[best] = (mdl_tail[best] + 1) % QUEUE_DEPTH;
        mdl_len[best]++;
        mdl_last_fin[best] = fin[TIME_W-1:0];
        d.server = SRVNUM_W'(best + 1);
        d.finish = fin[TIME_W-1:0];
        d.status = STAT_OK;
        return d;
    endfunction

    // Input driver: presents the next pending job at the falling edge and keeps
    // it steady until it is taken. Random bursts of idling between jobs.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (i_in_valid && !o_in_stall_q) begin
            // Accepted at the last rising edge: move on.
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= $urandom_range(1, 19);
            end else if (pending_jobs.size() > 0) begin
                i_arrival_time <= pending_jobs[0].arrival;
                i_service_time <= pending_jobs[0].service;
                void'(pending_jobs.pop_front());
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end else if (!i_in_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_jobs.size() > 0) begin
                i_arrival_time <= pending_jobs[0].arrival;
                i_service_time <= pending_jobs[0].service;
                void'(pending_jobs.pop_front());
                i_in_valid <= 1'b1;
            end
        end
    end

    // Output side stall: random bursts, none in the closing stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_gap    <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            if (recv_gap == 1) i_out_stall <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            recv_gap    <= $urandom_range(1, 19);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: predicts on every accepted job, checks every accepted result.
    always @(posedge i_clk) begin
        t_job      job;
        t_dispatch want;
        o_in_stall_q <= o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                job.arrival = i_arrival_time;
                job.service = i_service_time;
                expected_dispatches.push_back(predict_dispatch(job));
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_dispatches.size() == 0) begin
                    $error("result with no job outstanding: server %0d finish %0d status %0d",
                           o_server_number, o_finish_time, o_status);
                    error_count++;
                end else begin
                    want = expected_dispatches.pop_front();
                    if (o_server_number !== want.server) begin
                        $error("server_number: expected %0d, actual %0d",
                               want.server, o_server_number);
                        error_count++;
                    end
                    if (o_finish_time !== want.finish) begin
                        $error("finish_time: expected %0d, actual %0d",
                               want.finish, o_finish_time);
                        error_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        error_count++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_job(input logic [TIME_W-1:0] arrival,
                           input logic [SERVICE_W-1:0] service);
        t_job j;
        j.arrival = arrival;
        j.service = service;
        pending_jobs.push_back(j);
    endtask

    // Waits until every queued job has gone in and come back out, then lets
    // the block finish any walk still in flight.
    task automatic drain;
        while (pending_jobs.size() > 0 || i_in_valid || expected_dispatches.size() > 0)
            @(posedge i_clk);
        repeat (JOB_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_server_count(input logic [4:0] count);
        @(negedge i_clk);
        i_cfg_server_count <= count;
        i_cfg_valid        <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mdl_server_count = count;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random phase: mostly jobs whose arrival creeps forward so queues build
    // up and drain, plus occasional wide jumps and arrivals that go backward.
    task automatic queue_random_jobs(input int count, input logic [TIME_W-1:0] base,
                                     input int unsigned svc_max);
        logic [TIME_W-1:0] t;
        t = base;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    t = t + $urandom_range(0, 5000);
                    add_job(t, 16'($urandom_range(1, 65535)));
                end
                1:       add_job(t - $urandom_range(0, 50), 16'($urandom));
                default: begin
                    t = t + $urandom_range(0, 12);
                    add_job(t, 16'($urandom_range(1, svc_max)));
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_arrival_time     = '0;
        i_service_time     = '0;
        i_out_stall        = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_server_count = '0;
        o_in_stall_q       = 1'b1;
        error_count        = 0;
        idle_cycles        = 0;
        calm               = 1'b0;
        mdl_now            = '0;
        mdl_server_count   = 5'd16;
        for (int s = 0; s < MAX_SERVERS; s++) begin
            mdl_len[s]      = 0;
            mdl_head[s]     = 0;
            mdl_tail[s]     = 0;
            mdl_last_fin[s] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset count of 16: service time zero, minimum
        // and maximum service, ties filling servers in order, an arrival that
        // goes backward, and a departure landing exactly on an arrival.
        add_job(32'd0, 16'd0);
        add_job(32'd0, 16'd1);
        add_job(32'd1, 16'hFFFF);
        add_job(32'd0, 16'd5);
        add_job(32'd3, 16'd2);
        for (int k = 0; k < 12; k++) add_job(32'd3, 16'h5555);
        add_job(32'd3, 16'hAAAA);
        add_job(32'd7, 16'd1);
        drain();

        // One server: fill its queue to overflow the depth.
        write_server_count(5'd1);
        for (int k = 0; k < QUEUE_DEPTH + 2; k++) add_job(32'd100, 16'd3);
        drain();

        // Random part: each phase starts from the current effective arrival
        // time so queues keep building up and draining.
        write_server_count(5'd31);
        queue_random_jobs(300, mdl_now, 40);
        drain();
        write_server_count(5'd16);
        queue_random_jobs(300, mdl_now, 8);
        drain();
        write_server_count(5'd3);
        queue_random_jobs(400, mdl_now, 60);
        drain();
        write_server_count(5'($urandom_range(1, 31)));
        queue_random_jobs(500, mdl_now, 20);
        drain();
        write_server_count(5'd2);
        calm = 1'b1;
        queue_random_jobs(300, mdl_now, 30);
        drain();

        // Count zero acts as one; then near the top of time, finish overflow.
        // Time stays at the top afterwards, so this comes last.
        write_server_count(5'd0);
        add_job(32'hFFFF_FFF0, 16'd15);
        add_job(32'hFFFF_FFF0, 16'd1);
        add_job(32'hFFFF_FFFF, 16'hFFFF);
        drain();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
